// File: rtl/core/cmfr_pkg.sv
// Shared types, identifier bases and decode helpers for the motor feedback receiver.
package cmfr_pkg;

    // Identifier bases; the node number is added to each one.
    localparam logic [10:0] HB_BASE  = 11'h700;
    localparam logic [10:0] VL_BASE  = 11'h180;
    localparam logic [10:0] VR_BASE  = 11'h280;
    localparam logic [10:0] FLT_BASE = 11'h480;

    // Heartbeat payload codes.
    localparam logic [7:0] NMT_STOPPED = 8'h04;
    localparam logic [7:0] NMT_STARTED = 8'h05;
    localparam logic [7:0] NMT_PREOP   = 8'h7F;

    // Register map.
    localparam int unsigned REG_NODE_NUMBER = 0;
    localparam logic [6:0]  NODE_RESET      = 7'd4;

    // Number of listed faults in the one-hot fault word.
    localparam int unsigned NUM_FAULTS = 10;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_STOPPED = 2'd1,
        ST_STARTED = 2'd2,
        ST_PREOP   = 2'd3
    } node_state_t;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
    } frame_t;

    typedef struct packed {
        node_state_t        node_state;
        logic               driver_ready;
        logic               reinit_request;
        logic [15:0]        beat_count;
        logic [7:0]         last_beat_byte;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic [3:0]         fault_code;
    } result_t;

    // Map a one-hot fault word to a dense code; a clear word gives code zero, unlisted words keep the old code.
    function automatic logic [3:0] fault_decode(input logic [15:0] word,
                                                input logic [3:0]  cur);
        logic [3:0] code;
        code = cur;
        if (word == 16'd0)
        begin
            code = 4'd0;
        end
        for (int k = 0; k < NUM_FAULTS; k++)
        begin
            if (word == (16'd1 << k))
            begin
                code = 4'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

// File: rtl/core/canopen_motor_feedback_receiver_core.sv
// Top level of the CAN motor feedback receiver: frame decode, held values and register port.
// A frame beat passes through one input register, then the held-value registers
// that form the result beat.
// Throughput: one frame per cycle; the single-stage decode between the two
// register stages sets this figure, and the result stall backs up into the input.
// Reset: rst_n is asynchronous and active low; it clears all held values,
// empties both stages and sets the node number to 4.
module canopen_motor_feedback_receiver_core
    import cmfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Frame channel
    input  logic        frame_valid,
    output logic        frame_stall,
    input  frame_t      frame,
    // Result channel
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Input stage
    logic        s1_valid_reg, s1_valid_next;
    frame_t      s1_frame_reg;
    logic        frame_accept;
    logic        s2_load;

    // Held values, which also form the result register
    logic        res_valid_reg, res_valid_next;
    node_state_t state_reg, state_next;
    logic        configured_reg, configured_next;
    logic        reinit_reg, reinit_next;
    logic [15:0] beat_cnt_reg, beat_cnt_next;
    logic [7:0]  beat_byte_reg, beat_byte_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] right_reg, right_next;
    logic [3:0]  fault_reg, fault_next;

    // Configuration
    logic [6:0]  node_reg, node_next;
    logic        cfg_write;

    // Identifier matches
    logic [10:0] node_ext;
    logic        hit_hb, hit_vl, hit_vr, hit_flt;
    logic [31:0] le_word;

    // Handshake between the two stages
    assign s2_load      = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign frame_stall  = s1_valid_reg && !s2_load;
    assign frame_accept = frame_valid && !frame_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg && result_stall;
        if (s2_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    // Register port: a single register at byte address zero
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == 1'b0) ? {25'd0, node_reg} : 32'd0;

    always_comb
    begin
        node_next = node_reg;
        if (cfg_write && (paddr[2] == 1'(REG_NODE_NUMBER)))
        begin
            node_next = pwdata[6:0];
        end
    end

    // Frame decode against the four identifiers
    assign node_ext = {4'd0, node_reg};
    assign hit_hb   = (s1_frame_reg.frame_id == HB_BASE  + node_ext);
    assign hit_vl   = (s1_frame_reg.frame_id == VL_BASE  + node_ext);
    assign hit_vr   = (s1_frame_reg.frame_id == VR_BASE  + node_ext);
    assign hit_flt  = (s1_frame_reg.frame_id == FLT_BASE + node_ext);
    assign le_word  = {s1_frame_reg.byte3, s1_frame_reg.byte2,
                       s1_frame_reg.byte1, s1_frame_reg.byte0};

    // Next held values for the frame in the input stage
    always_comb
    begin
        state_next      = state_reg;
        configured_next = configured_reg;
        reinit_next     = reinit_reg;
        beat_cnt_next   = beat_cnt_reg;
        beat_byte_next  = beat_byte_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        fault_next      = fault_reg;

        if (hit_hb)
        begin
            beat_cnt_next  = beat_cnt_reg + 16'd1;
            beat_byte_next = s1_frame_reg.byte0;
            priority if (s1_frame_reg.byte0 == NMT_STOPPED)
            begin
                state_next = ST_STOPPED;
            end
            else if (s1_frame_reg.byte0 == NMT_STARTED)
            begin
                state_next      = ST_STARTED;
                configured_next = 1'b1;
            end
            else if (s1_frame_reg.byte0 == NMT_PREOP)
            begin
                state_next = ST_PREOP;
            end
            else
            begin
                // Any other heartbeat byte keeps the node state.
                state_next = state_reg;
            end
            if (state_next == ST_UNKNOWN && !configured_next)
            begin
                reinit_next = 1'b1;
            end
        end
        if (hit_vl)
        begin
            left_next = le_word;
        end
        if (hit_vr)
        begin
            right_next = le_word;
        end
        if (hit_flt)
        begin
            fault_next = fault_decode({s1_frame_reg.byte1, s1_frame_reg.byte0}, fault_reg);
        end
    end

    // Control and held-value registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            node_reg       <= NODE_RESET;
            state_reg      <= ST_UNKNOWN;
            configured_reg <= 1'b0;
            reinit_reg     <= 1'b0;
            beat_cnt_reg   <= 16'd0;
            beat_byte_reg  <= 8'd0;
            left_reg       <= 32'd0;
            right_reg      <= 32'd0;
            fault_reg      <= 4'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            node_reg      <= node_next;
            if (s2_load)
            begin
                state_reg      <= state_next;
                configured_reg <= configured_next;
                reinit_reg     <= reinit_next;
                beat_cnt_reg   <= beat_cnt_next;
                beat_byte_reg  <= beat_byte_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
                fault_reg      <= fault_next;
            end
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (frame_accept)
        begin
            s1_frame_reg <= frame;
        end
    end

    // Result beat
    assign result_valid          = res_valid_reg;
    assign result.node_state     = state_reg;
    assign result.driver_ready   = configured_reg;
    assign result.reinit_request = reinit_reg;
    assign result.beat_count     = beat_cnt_reg;
    assign result.last_beat_byte = beat_byte_reg;
    assign result.left_speed     = left_reg;
    assign result.right_speed    = right_reg;
    assign result.fault_code     = fault_reg;

`ifndef SYNTHESIS
    // The configured flag never clears once set.
    a_configured_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        configured_reg |=> configured_reg)
        else $error("configured flag cleared");

    // The re-initialise request never clears once set.
    a_reinit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        reinit_reg |=> reinit_reg)
        else $error("re-initialise request cleared");

    // A configured driver always has a known node state.
    a_configured_known: assert property (@(posedge clk) disable iff (!rst_n)
        configured_reg |-> (state_reg != ST_UNKNOWN))
        else $error("configured while node state unknown");

    // The beat counter only ever steps by one.
    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(beat_cnt_reg) |-> (beat_cnt_reg == $past(beat_cnt_reg) + 16'd1))
        else $error("beat counter jumped");

    // Held values change only when a frame moves out of the input stage.
    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_stall) |=> $stable(left_reg) && $stable(fault_reg))
        else $error("held value changed under a stalled result");
`endif

endmodule

// File: tb/sv/tb_canopen_motor_feedback_receiver_core.sv
// Self-checking testbench for the CANopen motor feedback receiver core.
module tb_canopen_motor_feedback_receiver_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cmfr_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned PHASE_FRAMES   = 244;
    localparam int unsigned IDLE_PERCENT   = 12;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [2:0]  NODE_ADDR      = 3'(4 * REG_NODE_NUMBER);

    // Mirror of the held values; each accepted frame yields one expected result.
    class feedback_tracker;
        logic [6:0]         node;
        node_state_t        state;
        logic               configured;
        logic               reinit;
        logic [15:0]        beats;
        logic [7:0]         beat_byte;
        logic signed [31:0] left_vel;
        logic signed [31:0] right_vel;
        logic [3:0]         fault;
        result_t            expected_feedback[$];
        int unsigned        mismatches;
        int unsigned        frames_seen;
        int unsigned        results_seen;

        function new();
            node         = NODE_RESET;
            state        = ST_UNKNOWN;
            configured   = 1'b0;
            reinit       = 1'b0;
            beats        = '0;
            beat_byte    = '0;
            left_vel     = '0;
            right_vel    = '0;
            fault        = '0;
            mismatches   = 0;
            frames_seen  = 0;
            results_seen = 0;
        endfunction

        function void set_node(input logic [6:0] n);
            node = n;
        endfunction

        function int unsigned pending();
            return expected_feedback.size();
        endfunction

        function void report(input string what, input logic [31:0] want,
                             input logic [31:0] got);
            if (mismatches < REPORT_LIMIT)
            begin
                $display("MISMATCH result %0d %s: expected %0h, got %0h",
                         results_seen, what, want, got);
            end
            mismatches++;
        endfunction

        // Apply one frame to the held values and queue the result it produces.
        function void note_frame(input frame_t f);
            logic [15:0] word;
            result_t     r;
            frames_seen++;
            if (f.frame_id == HB_BASE + 11'(node))
            begin
                beats     = beats + 16'd1;
                beat_byte = f.byte0;
                if (f.byte0 == NMT_STOPPED)
                begin
                    state = ST_STOPPED;
                end
                else if (f.byte0 == NMT_STARTED)
                begin
                    state      = ST_STARTED;
                    configured = 1'b1;
                end
                else if (f.byte0 == NMT_PREOP)
                begin
                    state = ST_PREOP;
                end
                if (state == ST_UNKNOWN && !configured)
                begin
                    reinit = 1'b1;
                end
            end
            else if (f.frame_id == VL_BASE + 11'(node))
            begin
                left_vel = {f.byte3, f.byte2, f.byte1, f.byte0};
            end
            else if (f.frame_id == VR_BASE + 11'(node))
            begin
                right_vel = {f.byte3, f.byte2, f.byte1, f.byte0};
            end
            else if (f.frame_id == FLT_BASE + 11'(node))
            begin
                // Only a clear word or a single listed bit changes the code.
                word = {f.byte1, f.byte0};
                if (word == '0)
                begin
                    fault = '0;
                end
                else if ($countones(word) == 1 && word[15:NUM_FAULTS] == '0)
                begin
                    for (int k = 0; k < NUM_FAULTS; k++)
                    begin
                        if (word[k])
                        begin
                            fault = 4'(k + 1);
                        end
                    end
                end
            end
            r.node_state     = state;
            r.driver_ready   = configured;
            r.reinit_request = reinit;
            r.beat_count     = beats;
            r.last_beat_byte = beat_byte;
            r.left_speed     = left_vel;
            r.right_speed    = right_vel;
            r.fault_code     = fault;
            expected_feedback.push_back(r);
        endfunction

        // Compare one accepted result beat with the oldest expectation.
        function void check_result(input result_t got);
            result_t want;
            if (expected_feedback.size() == 0)
            begin
                report("unexpected beat", '0, '0);
            end
            else
            begin
                want = expected_feedback.pop_front();
                if (got.node_state !== want.node_state)
                begin
                    report("node_state", 32'(want.node_state), 32'(got.node_state));
                end
                if (got.driver_ready !== want.driver_ready)
                begin
                    report("driver_ready", 32'(want.driver_ready), 32'(got.driver_ready));
                end
                if (got.reinit_request !== want.reinit_request)
                begin
                    report("reinit_request", 32'(want.reinit_request),
                           32'(got.reinit_request));
                end
                if (got.beat_count !== want.beat_count)
                begin
                    report("beat_count", 32'(want.beat_count), 32'(got.beat_count));
                end
                if (got.last_beat_byte !== want.last_beat_byte)
                begin
                    report("last_beat_byte", 32'(want.last_beat_byte),
                           32'(got.last_beat_byte));
                end
                if (got.left_speed !== want.left_speed)
                begin
                    report("left_speed", want.left_speed, got.left_speed);
                end
                if (got.right_speed !== want.right_speed)
                begin
                    report("right_speed", want.right_speed, got.right_speed);
                end
                if (got.fault_code !== want.fault_code)
                begin
                    report("fault_code", 32'(want.fault_code), 32'(got.fault_code));
                end
            end
            results_seen++;
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        frame_valid  = 1'b0;
    logic        frame_stall;
    frame_t      frame        = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    feedback_tracker tracker;
    bit              calm = 1'b0;
    int unsigned     quiet_cycles = 0;
    int unsigned     node_settings = 0;

    canopen_motor_feedback_receiver_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 clk = ~clk;

    // Result side: check each accepted beat, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            tracker.check_result(result);
        end
        result_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: give up once nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (frame_valid && !frame_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles without a beat", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one frame, with an occasional one-cycle gap first, and wait until it is accepted.
    task automatic send_frame(input frame_t f);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        @(posedge clk);
        while (frame_stall)
        begin
            @(posedge clk);
        end
        tracker.note_frame(f);
    endtask

    // Data is given as {byte3, byte2, byte1, byte0}.
    task automatic send_raw(input logic [10:0] id, input logic [31:0] data);
        frame_t f;
        f.frame_id = id;
        {f.byte3, f.byte2, f.byte1, f.byte0} = data;
        send_frame(f);
    endtask

    // Stop sending and hold off until every outstanding result has been checked.
    task automatic drain();
        frame_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write the node number, then read it back over the register port.
    task automatic configure_node(input logic [6:0] n);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= NODE_ADDR;
        pwdata  <= 32'(n);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata[6:0] !== n)
        begin
            tracker.report("node_number read-back", 32'(n), 32'(prdata[6:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        tracker.set_node(n);
        node_settings++;
    endtask

    // Mostly frames addressed to this node, some near misses and stray identifiers.
    function automatic frame_t random_frame(input logic [6:0] n);
        frame_t      f;
        int unsigned pick;
        int unsigned sel;
        logic [15:0] word;
        logic [10:0] bases[4];
        pick     = $urandom_range(0, 99);
        sel      = $urandom_range(0, 9);
        bases    = '{HB_BASE, VL_BASE, VR_BASE, FLT_BASE};
        f.byte0  = 8'($urandom);
        f.byte1  = 8'($urandom);
        f.byte2  = 8'($urandom);
        f.byte3  = 8'($urandom);
        if (pick < 22)
        begin
            f.frame_id = HB_BASE + 11'(n);
            case (sel % 4)
                0: f.byte0 = NMT_STOPPED;
                1: f.byte0 = NMT_STARTED;
                2: f.byte0 = NMT_PREOP;
                default: ;
            endcase
        end
        else if (pick < 60)
        begin
            f.frame_id = (pick < 41) ? VL_BASE + 11'(n) : VR_BASE + 11'(n);
            if (sel == 0)
            begin
                {f.byte3, f.byte2, f.byte1, f.byte0} = 32'h8000_0000;
            end
            else if (sel == 1)
            begin
                {f.byte3, f.byte2, f.byte1, f.byte0} = 32'h7FFF_FFFF;
            end
        end
        else if (pick < 82)
        begin
            f.frame_id = FLT_BASE + 11'(n);
            if (sel < 6)
            begin
                word = 16'd1 << $urandom_range(0, NUM_FAULTS - 1);
            end
            else if (sel == 6)
            begin
                word = '0;
            end
            else if (sel == 7)
            begin
                word = 16'd1 << $urandom_range(NUM_FAULTS, 15);
            end
            else if (sel == 8)
            begin
                word = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
            end
            else
            begin
                word = 16'($urandom);
            end
            {f.byte1, f.byte0} = word;
        end
        else if (pick < 90)
        begin
            f.frame_id = bases[$urandom_range(0, 3)] + 11'(n);
            f.frame_id = (sel < 5) ? f.frame_id + 11'd1 : f.frame_id - 11'd1;
        end
        else
        begin
            f.frame_id = 11'($urandom_range(0, 2047));
        end
        return f;
    endfunction

    initial
    begin
        logic [10:0] hb;
        logic [10:0] vl;
        logic [10:0] vr;
        logic [10:0] flt;
        logic [6:0]  node;

        tracker = new();
        hb      = HB_BASE + 11'(NODE_RESET);
        vl      = VL_BASE + 11'(NODE_RESET);
        vr      = VR_BASE + 11'(NODE_RESET);
        flt     = FLT_BASE + 11'(NODE_RESET);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset node number.
        send_raw(11'h000, 32'h0000_0000);
        send_raw(11'h7FF, 32'hFFFF_FFFF);
        // A heartbeat with an unknown state before any start raises the request.
        send_raw(hb, 32'h0000_0000);
        send_raw(vl, 32'h8000_0000);
        send_raw(vr, 32'h7FFF_FFFF);
        send_raw(vl, 32'hFFFF_FFFF);
        send_raw(flt, 32'h0000_0001);
        send_raw(flt, 32'hFFFF_0200);
        send_raw(flt, 32'h0000_0400);
        send_raw(flt, 32'h0000_0003);
        send_raw(flt, 32'hFFFF_FFFF);
        send_raw(flt, 32'h0000_0000);
        send_raw(hb, {24'h0, NMT_STOPPED});
        send_raw(hb, {24'h0, NMT_PREOP});
        send_raw(hb, 32'hFFFF_FFFF);
        send_raw(hb, {24'h0, NMT_STARTED});
        send_raw(hb, {24'hFF_FFFF, NMT_STOPPED});
        send_raw(hb - 11'd1, {24'h0, NMT_PREOP});
        send_raw(hb + 11'd1, {24'h0, NMT_PREOP});
        send_raw(vr, 32'h0000_0000);
        send_raw(vl + 11'h100, 32'h1234_5678);

        // Random phases, each after setting a node number; one phase runs without idling.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: node = 7'd1;
                1: node = 7'd127;
                2: node = 7'd0;
                3: node = NODE_RESET;
                default: node = 7'($urandom_range(0, 127));
            endcase
            configure_node(node);
            calm = (phase == 2);
            for (int i = 0; i < PHASE_FRAMES; i++)
            begin
                send_frame(random_frame(node));
            end
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d frames over %0d node number settings, including zero and 127.",
                 tracker.frames_seen, node_settings + 1);
        $display("Checked %0d result beats; %0d mismatches.",
                 tracker.results_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/cmfr_pkg.sv
rtl/core/canopen_motor_feedback_receiver_core.sv
tb/sv/tb_canopen_motor_feedback_receiver_core.sv
